// ===== hw/rtl/dcagc_pkg.sv =====
// Package for the DC-blocking AGC half-symbol slicer.
// Holds fixed-point constants, controller state type and command/status structs.
package dcagc_pkg;
    localparam int SAMPLE_WIDTH = 16;

    localparam logic [31:0] K_DC_OLD  = 32'd2136746230;
    localparam logic [31:0] K_DC_NEW  = 32'd10737418;
    localparam logic [31:0] K_AT_OLD  = 32'd1932735283;
    localparam logic [31:0] K_AT_NEW  = 32'd214748365;
    localparam logic [31:0] K_DE_OLD  = 32'd2147268900;
    localparam logic [31:0] K_DE_NEW  = 32'd214748;
    localparam logic [31:0] K_G_OLD   = 32'd2126008812;
    localparam logic [31:0] K_G_NEW   = 32'd21474836;
    localparam logic [31:0] LEVEL_MIN = 32'd2147484;
    localparam logic [30:0] GAIN_MIN  = 31'd167772;
    localparam logic [30:0] GAIN_MAX  = 31'd1677721600;
    localparam logic [30:0] GAIN_ONE  = 31'd16777216;
    localparam logic [15:0] PHASE_ONE = 16'd256;
    localparam logic [15:0] PERIOD_RESET = 16'd1920;

    // Restoring divider: quotient bits needed for 2^54 / peak (peak > 2^21).
    localparam int DIV_BITS = 34;
    localparam int DIV_CNT_W = 6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DC,
        ST_PEAK,
        ST_DIV,
        ST_GAIN,
        ST_PROD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;      // capture input sample
        logic do_dc;     // DC tracker update
        logic do_peak;   // peak tracker update
        logic div_start; // begin division
        logic div_step;  // one restoring step
        logic do_gain;   // gain update
        logic do_prod;   // gained sample and phase update
    } dp_cmd_t;

    typedef struct packed {
        logic agc_on;    // peak above threshold
        logic div_done;  // last quotient bit produced
        logic emit;      // phase wrapped, result ready
    } dp_status_t;
endpackage

// ===== hw/rtl/dcagc_ctrl.sv =====
// Controller state machine of the slicer: sequences the datapath steps.
// Depends on dcagc_pkg.
module dcagc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output dcagc_pkg::dp_cmd_t    cmd,
    input  dcagc_pkg::dp_status_t status
);
    import dcagc_pkg::*;

    state_t state_reg, state_next;
    logic   mvalid_reg, mvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign m_valid = mvalid_reg;
    // The output register may hold a result while the next sample is taken;
    // a new result is only written once the old one is gone.
    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next  = state_reg;
        mvalid_next = mvalid_reg;
        cmd         = '0;
        if (mvalid_reg && m_ready) mvalid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DC;
                end
            end
            ST_DC: begin
                cmd.do_dc  = 1'b1;
                state_next = ST_PEAK;
            end
            ST_PEAK: begin
                cmd.do_peak = 1'b1;
                state_next  = ST_GAIN;
            end
            ST_GAIN: begin
                if (status.agc_on) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end else begin
                    state_next = ST_PROD;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                cmd.do_gain = 1'b1;
                state_next  = ST_PROD;
            end
            ST_PROD: begin
                if (!mvalid_reg || m_ready) begin
                    cmd.do_prod = 1'b1;
                    if (status.emit) mvalid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

// ===== hw/rtl/dcagc_dp.sv =====
// Datapath of the slicer: filter state, serial divider, product and phase.
// Depends on dcagc_pkg.
module dcagc_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic signed [dcagc_pkg::SAMPLE_WIDTH-1:0] s_sample,
    input  logic [15:0]                          cfg_wdata,
    input  logic                                 cfg_we,
    input  dcagc_pkg::dp_cmd_t                   cmd,
    output dcagc_pkg::dp_status_t                status,
    output logic                                 m_half_symbol_level,
    output logic signed [dcagc_pkg::SAMPLE_WIDTH-1:0] m_normalized_sample
);
    import dcagc_pkg::*;

    localparam int SW = SAMPLE_WIDTH;

    logic signed [31:0] dc_reg;
    logic [31:0]        peak_reg;
    logic [30:0]        gain_reg;
    logic [15:0]        phase_reg;
    logic [15:0]        period_reg;
    logic signed [31:0] x_reg;
    logic [32:0]        mag_reg;
    logic               neg_reg;
    logic [54:0]        rem_reg;
    logic [DIV_BITS-1:0] quo_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic               level_reg;
    logic signed [SW-1:0] norm_reg;

    // DC tracker: products are 32x32, one per factor, summed and rounded.
    logic signed [65:0] dc_sum;
    logic signed [65:0] dc_rnd;
    logic signed [34:0] dc_q;
    logic signed [31:0] dc_new;
    logic signed [32:0] diff;
    always_comb begin
        dc_sum = $signed({1'b0, K_DC_OLD}) * dc_reg + $signed({1'b0, K_DC_NEW}) * x_reg;
        // Half toward plus infinity: bias negatives by half minus one.
        if (dc_sum >= 0) dc_rnd = dc_sum + 66'sd1073741824;
        else dc_rnd = -((-dc_sum) + 66'sd1073741823);
        if (dc_sum >= 0) dc_q = 35'(dc_rnd >>> 31);
        else dc_q = -35'((-dc_rnd) >>> 31);
        if (dc_q > 35'sd2147483647) dc_new = 32'sh7fffffff;
        else if (dc_q < -35'sd2147483648) dc_new = 32'sh80000000;
        else dc_new = dc_q[31:0];
        // The sample is taken against the updated estimate.
        diff = 33'(x_reg) - 33'(dc_new);
    end

    // Peak tracker.
    logic        attack;
    logic [65:0] pk_sum;
    logic [34:0] pk_q;
    always_comb begin
        attack = mag_reg > {1'b0, peak_reg};
        if (attack) pk_sum = 66'(K_AT_OLD * 64'(peak_reg)) + 66'(K_AT_NEW * 65'(mag_reg));
        else pk_sum = 66'(K_DE_OLD * 64'(peak_reg)) + 66'(K_DE_NEW * 65'(mag_reg));
        pk_q = 35'((pk_sum + 66'd1073741824) >> 31);
    end

    // Divider step and gain update. The dividend is 2^54 + peak/2; its bits
    // enter the remainder from bit DIV_BITS-1 down to bit 0, one per step.
    logic [54:0] dividend;
    logic        dbit;
    assign dividend = (55'd1 << 54) + 55'(peak_reg[31:1]);
    assign dbit     = dividend[6'(DIV_BITS - 1) - cnt_reg];

    logic [55:0] trial;
    logic [64:0] g_sum;
    logic [33:0] g_q;
    always_comb begin
        trial = {rem_reg, dbit} - {24'd0, peak_reg};
        g_sum = 65'(K_G_OLD * 63'(gain_reg)) + 65'(K_G_NEW * 66'(quo_reg));
        g_q = 34'((g_sum + 65'd1073741824) >> 31);
    end

    // Gained sample.
    logic [63:0] prod_full;
    logic [63:0] prod;
    logic signed [SW-1:0] normv;
    logic [15:0] period_eff;
    logic [16:0] ph;
    always_comb begin
        prod_full = 64'(mag_reg) * 64'(gain_reg);
        prod = (prod_full + (64'd1 << (55 - SW))) >> (56 - SW);
        if (neg_reg) begin
            if (prod > (64'd1 << (SW - 1))) normv = {1'b1, {(SW-1){1'b0}}};
            else normv = SW'(-prod);
        end else begin
            if (prod > ((64'd1 << (SW - 1)) - 64'd1)) normv = {1'b0, {(SW-1){1'b1}}};
            else normv = SW'(prod);
        end
        period_eff = (period_reg < PHASE_ONE) ? PHASE_ONE : period_reg;
        ph = {1'b0, phase_reg} + {1'b0, PHASE_ONE};
    end

    assign status = {peak_reg > LEVEL_MIN,
                     cnt_reg == DIV_CNT_W'(DIV_BITS - 1),
                     ph >= {1'b0, period_eff}};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dc_reg     <= '0;
            peak_reg   <= '0;
            gain_reg   <= GAIN_ONE;
            phase_reg  <= '0;
            period_reg <= PERIOD_RESET;
        end else begin
            if (cfg_we) period_reg <= cfg_wdata;
            if (cmd.do_dc) dc_reg <= dc_new;
            if (cmd.do_peak) peak_reg <= (pk_q > 35'h0ffffffff) ? 32'hffffffff : pk_q[31:0];
            if (cmd.do_gain) begin
                if (g_q < 34'(GAIN_MIN)) gain_reg <= GAIN_MIN;
                else if (g_q > 34'(GAIN_MAX)) gain_reg <= GAIN_MAX;
                else gain_reg <= g_q[30:0];
            end
            if (cmd.do_prod) begin
                if (status.emit) phase_reg <= 16'(ph - {1'b0, period_eff});
                else phase_reg <= ph[15:0];
            end
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge aclk) begin
        if (cmd.load) x_reg <= 32'(s_sample) <<< (32 - SW);
        if (cmd.do_dc) begin
            neg_reg <= diff < 0;
            mag_reg <= (diff < 0) ? 33'(-diff) : 33'(diff);
        end
        if (cmd.div_start) begin
            // The dividend bits above the quotient width seed the remainder.
            rem_reg <= dividend >> DIV_BITS;
            quo_reg <= '0;
            cnt_reg <= '0;
        end else if (cmd.div_step) begin
            if (!trial[55]) begin
                rem_reg <= trial[54:0];
                quo_reg <= {quo_reg[DIV_BITS-2:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[53:0], dbit};
                quo_reg <= {quo_reg[DIV_BITS-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg + DIV_CNT_W'(1);
        end
        if (cmd.do_prod && status.emit) begin
            level_reg <= (normv > 0);
            norm_reg  <= normv;
        end
    end

    assign m_half_symbol_level = level_reg;
    assign m_normalized_sample = norm_reg;
endmodule

// ===== hw/rtl/dc_agc_half_symbol_slicer.sv =====
// DC-blocking peak AGC with a half-symbol slicer, top level.
// Each sample passes the DC, peak and gain-check states, then, while the AGC is active, the
// 34-step restoring divider for the gain target, the gain update and the product state, which
// holds while a result waits at the output. A new sample is taken only once the last is through.
// Reset (synchronous, aresetn low) clears DC and peak state, sets gain to 1.0, phase to 0,
// and the half-symbol period to 7.5 samples.
module dc_agc_half_symbol_slicer (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [dcagc_pkg::SAMPLE_WIDTH-1:0] s_sample,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_half_symbol_level,
    output logic signed [dcagc_pkg::SAMPLE_WIDTH-1:0] m_normalized_sample,
    input  logic                                 cfg_we,
    input  logic [15:0]                          cfg_wdata
);
    import dcagc_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // The controller steps each transaction through DC, peak, divide and gain (while the AGC is active) and product.
    dcagc_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .cmd(cmd), .status(status)
    );

    // The datapath holds all filter state and the output register.
    dcagc_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .s_sample(s_sample),
        .cfg_wdata(cfg_wdata), .cfg_we(cfg_we), .cmd(cmd), .status(status),
        .m_half_symbol_level(m_half_symbol_level),
        .m_normalized_sample(m_normalized_sample)
    );

    // A result must never be overwritten while still waiting.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid) else $error("result lost");
    // The level bit always matches the sign of the sample it goes with.
    a_level_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_half_symbol_level == (m_normalized_sample > 0)))
        else $error("level mismatch");
    // Only one input transaction is in flight at a time.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready) else $error("second transaction taken");
endmodule
